[design/rspd_pkg.sv]
// Package for the run segment pattern detector: request types, class codes,
// pattern matcher step and configuration port constants.
// No dependencies.
`timescale 1ns / 1ps

package rspd_pkg;

  localparam int MAX_ROW_PIXELS_DEF = 4096;

  // Pattern matcher
  localparam int PAT_LEN = 5;
  localparam int MP_W    = 3;

  // Class codes
  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_BLACK = 2'd1;
  localparam logic [1:0] CLS_GRAY  = 2'd2;
  localparam logic [1:0] CLS_WHITE = 2'd3;

  localparam logic [7:0] PIX_BLACK = 8'd0;
  localparam logic [7:0] PIX_GRAY  = 8'd128;
  localparam logic [7:0] PIX_WHITE = 8'd255;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Output queue
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = 2;
  localparam int FQ_CNT_W = 3;

  typedef logic [PAT_LEN-1:0][1:0] pattern_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } in_item_t;

  typedef struct packed {
    logic [12:0] segment_number;
    logic [1:0]  color_class;
    logic [12:0] run_length;
    logic [11:0] midpoint;
    logic        pattern_found;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [MP_W-1:0] mp;
    logic            found;
  } match_t;

  // Results handed from the run tracker to the output queue
  typedef struct packed {
    logic [1:0]           cnt;
    out_item_t [1:0]      res;
  } rspd_push_t;

  localparam pattern_t PATTERN_RST = {2'd1, 2'd3, 2'd2, 2'd3, 2'd1};

  function automatic logic [1:0] class_of(logic [7:0] v);
    logic [1:0] c;
    c = CLS_OTHER;
    if (v == PIX_BLACK) c = CLS_BLACK;
    else if (v == PIX_GRAY) c = CLS_GRAY;
    else if (v == PIX_WHITE) c = CLS_WHITE;
    return c;
  endfunction

  // One matcher step; restart compares against the first entry only
  function automatic match_t match_step(match_t cur, pattern_t pat, logic [1:0] cls);
    logic [MP_W-1:0] mp;
    match_t          res;
    mp = (cur.mp >= MP_W'(PAT_LEN)) ? '0 : cur.mp;
    res.found = cur.found;
    if (pat[mp] == cls) begin
      if (mp == MP_W'(PAT_LEN - 1)) begin
        res.found = 1'b1;
        res.mp    = '0;
      end else begin
        res.mp = MP_W'(mp + MP_W'(1));
      end
    end else begin
      res.mp = (pat[0] == cls) ? MP_W'(1) : '0;
    end
    return res;
  endfunction

endpackage

[design/rspd_core.sv]
// Run tracker: row state, run closing, midpoint and pattern matching.
// Produces up to two results per accepted request. Depends on rspd_pkg.
`timescale 1ns / 1ps

module rspd_core #(
  parameter int MAX_ROW_PIXELS = rspd_pkg::MAX_ROW_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  rspd_pkg::in_item_t  in_item,
  input  rspd_pkg::pattern_t  pattern,
  output rspd_pkg::rspd_push_t push
);
  import rspd_pkg::*;

  localparam int POS_W = (MAX_ROW_PIXELS > 2) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int CNT_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [7:0]       prev_r, prev_nxt;
  logic [CNT_W-1:0] run_len_r, run_len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] seg_r, seg_nxt;
  match_t           match_r, match_nxt;

  logic             change, last;
  logic [CNT_W-1:0] len2, seg1, seg2;
  logic [1:0]       cls1, cls2;
  match_t           m1, m2;
  logic [SUM_W-1:0] start1, end1, start2, end2, sum1, sum2;
  out_item_t        r1, r2;

  always_comb begin
    change = (run_len_r != '0) && (in_item.pixel != prev_r);
    last   = in_item.row_end || (pos_r == POS_W'(MAX_ROW_PIXELS - 1));

    // Old run, closed by a value change
    cls1   = class_of(prev_r);
    seg1   = CNT_W'(seg_r + CNT_W'(1));
    m1     = match_step(match_r, pattern, cls1);
    end1   = SUM_W'(pos_r) - SUM_W'(1);
    start1 = SUM_W'(pos_r) - SUM_W'(run_len_r);
    sum1   = SUM_W'(start1 + end1);

    // Run holding the current pixel, closed at row end
    len2   = change ? CNT_W'(1) : CNT_W'(run_len_r + CNT_W'(1));
    cls2   = class_of(in_item.pixel);
    seg2   = change ? CNT_W'(seg1 + CNT_W'(1)) : seg1;
    m2     = match_step(change ? m1 : match_r, pattern, cls2);
    end2   = SUM_W'(pos_r);
    start2 = SUM_W'(SUM_W'(pos_r) + SUM_W'(1) - SUM_W'(len2));
    sum2   = SUM_W'(start2 + end2);

    r1.segment_number = 13'(seg1);
    r1.color_class    = cls1;
    r1.run_length     = 13'(run_len_r);
    r1.midpoint       = 12'(sum1 >> 1);
    r1.pattern_found  = m1.found;
    r1.last_result    = !last;

    r2.segment_number = 13'(seg2);
    r2.color_class    = cls2;
    r2.run_length     = 13'(len2);
    r2.midpoint       = 12'(sum2 >> 1);
    r2.pattern_found  = m2.found;
    r2.last_result    = 1'b1;

    // Slot 0 carries the first result of the request
    push.res[0] = change ? r1 : r2;
    push.res[1] = r2;
    push.cnt    = '0;
    if (acc) push.cnt = 2'(change) + 2'(last);
  end

  always_comb begin
    prev_nxt    = prev_r;
    run_len_nxt = run_len_r;
    pos_nxt     = pos_r;
    seg_nxt     = seg_r;
    match_nxt   = match_r;
    if (acc) begin
      if (last) begin
        prev_nxt    = '0;
        run_len_nxt = '0;
        pos_nxt     = '0;
        seg_nxt     = '0;
        match_nxt   = '0;
      end else begin
        prev_nxt    = in_item.pixel;
        run_len_nxt = len2;
        pos_nxt     = POS_W'(pos_r + POS_W'(1));
        seg_nxt     = change ? seg1 : seg_r;
        match_nxt   = change ? m1 : match_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      run_len_r <= '0;
      pos_r     <= '0;
      seg_r     <= '0;
      match_r   <= '0;
    end else begin
      prev_r    <= prev_nxt;
      run_len_r <= run_len_nxt;
      pos_r     <= pos_nxt;
      seg_r     <= seg_nxt;
      match_r   <= match_nxt;
    end
  end

  // Row end wipes all row state
  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_item.row_end |=> run_len_r == '0 && seg_r == '0 && !match_r.found)
    else $error("row state not cleared after row end");

  // A live run always has a length bounded by the position
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(run_len_r) <= SUM_W'(pos_r))
    else $error("run length exceeds row position");

  // Found flag drops only at the end of a row
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(match_r.found) |-> $past(acc) && $past(last))
    else $error("found flag dropped mid row");

endmodule

[design/run_segment_pattern_detector.sv]
// Top level of the run segment pattern detector: pattern registers on the
// APB-style port, run tracker and a four-entry result queue.
// Depends on rspd_pkg and rspd_core.
`timescale 1ns / 1ps

// One pixel request is taken per clock while in_stall is low. Runs of equal
// pixel value are closed on a value change or at the row's last pixel
// (row_end, or the pixel at index MAX_ROW_PIXELS-1), and each closed run
// leaves one result with its number, class, length, midpoint and the sticky
// pattern-found flag; a pixel that both changes value and ends the row
// leaves two results, the older run first. Results go through a four-entry
// queue: a request is taken at any edge where at least two entries are free,
// so a row flows at one pixel per cycle while results drain, and the queue
// drains one result per cycle while out_stall is low. in_stall is high while
// the queue holds three or more results; that happens when the consumer
// holds out_stall, or when pixels that leave two results arrive faster than
// one result per cycle drains. out_valid rises in the cycle after acceptance
// when the queue is empty. Pattern registers live at byte addresses 0,4,..,16
// and should be written only while the block is idle.
module run_segment_pattern_detector #(
  parameter int MAX_ROW_PIXELS = rspd_pkg::MAX_ROW_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pixel requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rspd_pkg::in_item_t                  in_data,
  // Results
  output logic                                out_valid,
  input  logic                                out_stall,
  output rspd_pkg::out_item_t                 out_data,
  // Configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rspd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rspd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rspd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import rspd_pkg::*;

  // ---------------- configuration registers ----------------
  pattern_t             pat_r, pat_nxt;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_IDX_W+1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    pat_nxt = pat_r;
    if (cfg_wr && (cfg_idx < CFG_IDX_W'(PAT_LEN))) pat_nxt[cfg_idx] = cfg_pwdata[1:0];
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx < CFG_IDX_W'(PAT_LEN)) cfg_prdata = CFG_DATA_W'(pat_r[cfg_idx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pat_r <= PATTERN_RST;
    else        pat_r <= pat_nxt;
  end

  // ---------------- run tracker ----------------
  logic       in_acc;
  rspd_push_t push;

  assign in_acc = in_valid && !in_stall;

  rspd_core #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .in_item(in_data),
    .pattern(pat_r),
    .push   (push)
  );

  // ---------------- result queue ----------------
  out_item_t           fq_mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = fq_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for two results is needed before taking a pixel
  assign in_stall  = (cnt_r > FQ_CNT_W'(FQ_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = FQ_PTR_W'(wr_ptr_r + FQ_PTR_W'(push.cnt));
    rd_ptr_nxt = FQ_PTR_W'(rd_ptr_r + FQ_PTR_W'(pop));
    cnt_nxt    = FQ_CNT_W'(cnt_r + FQ_CNT_W'(push.cnt) - FQ_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) fq_mem[wr_ptr_r] <= push.res[0];
    if (push.cnt == 2'd2) fq_mem[FQ_PTR_W'(wr_ptr_r + FQ_PTR_W'(1))] <= push.res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue never overflows
  a_fq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FQ_CNT_W'(FQ_DEPTH))
    else $error("result queue overflow");

  // Occupancy matches the pointer distance
  a_fq_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == FQ_CNT_W'(FQ_DEPTH)) || (FQ_PTR_W'(wr_ptr_r - rd_ptr_r) == FQ_PTR_W'(cnt_r)))
    else $error("queue pointers disagree with count");

  // A request that ends a row always leaves a final result behind
  a_row_end_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.row_end |-> push.cnt != 2'd0 &&
      ((push.cnt == 2'd1 && push.res[0].last_result) ||
       (push.cnt == 2'd2 && push.res[1].last_result && !push.res[0].last_result)))
    else $error("row end without final result");

endmodule

[tb/sv/tb_top.sv]
// Testbench for run_segment_pattern_detector: directed and random pixel rows,
// pattern register writes and reads on the APB-style port, per-field result checks.
// Depends on rspd_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb_top;
  import rspd_pkg::*;

  localparam int REG_STRIDE = 4;      // byte spacing of the pattern registers
  localparam int MAX_SHOWN  = 10;     // mismatches printed in full
  localparam int ROW_LIMIT  = MAX_ROW_PIXELS_DEF;

  // Clock, reset and DUT ports; every input known from time zero
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Idling controls, shared by the request driver and the stall driver
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  int stall_left = 0;

  // Bookkeeping
  out_item_t pending_runs[$];   // predicted run results, oldest first
  int        mismatches  = 0;
  int        pixels_sent = 0;

  // Predictor state: a private copy of the run tracker and the matcher
  pattern_t    pattern_regs = PATTERN_RST;
  logic [7:0]  last_pix     = '0;
  logic [12:0] run_len      = '0;
  logic [11:0] pix_pos      = '0;   // index of the next pixel in the row
  logic [12:0] runs_closed  = '0;
  logic [2:0]  match_pos    = '0;
  logic        found_seen   = 1'b0;

  run_segment_pattern_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Error reporting
  // ---------------------------------------------------------------------------
  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic string run_text(out_item_t r);
    return $sformatf("seg=%0d cls=%0d len=%0d mid=%0d found=%0b last=%0b",
                     r.segment_number, r.color_class, r.run_length, r.midpoint,
                     r.pattern_found, r.last_result);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Closes one run: bumps the run count, classifies the value, steps the
  // matcher and builds the result (last_result is patched by the caller).
  function automatic out_item_t close_run(logic [7:0] pix, logic [12:0] len, int last_idx);
    out_item_t  r;
    logic [1:0] cls;
    int         first_idx;
    int         mp;
    case (pix)
      PIX_BLACK: cls = CLS_BLACK;
      PIX_GRAY:  cls = CLS_GRAY;
      PIX_WHITE: cls = CLS_WHITE;
      default:   cls = CLS_OTHER;
    endcase
    first_idx   = last_idx - (int'(len) - 1);
    runs_closed = runs_closed + 13'd1;
    // Matcher: advance on a hit; on a miss only the first entry is retried
    mp = (int'(match_pos) >= PAT_LEN) ? 0 : int'(match_pos);
    if (pattern_regs[mp] == cls) begin
      mp++;
      if (mp == PAT_LEN) begin
        found_seen = 1'b1;
        mp = 0;
      end
    end else begin
      mp = (pattern_regs[0] == cls) ? 1 : 0;
    end
    match_pos        = 3'(mp);
    r.segment_number = runs_closed;
    r.color_class    = cls;
    r.run_length     = len;
    r.midpoint       = 12'((first_idx + last_idx) / 2);
    r.pattern_found  = found_seen;
    r.last_result    = 1'b0;
    return r;
  endfunction

  // Works out the results of one accepted pixel and queues them.
  function automatic void predict_pixel(logic [7:0] pix, logic rend);
    out_item_t closed[2];
    int        n;
    int        i;
    n = 0;
    // value change closes the previous run
    if (run_len != 0 && pix != last_pix) begin
      closed[n] = close_run(last_pix, run_len, int'(pix_pos) - 1);
      n++;
      run_len = '0;
    end
    run_len  = run_len + 13'd1;
    last_pix = pix;
    // row end, or the forced end at the row length limit
    if (rend || int'(pix_pos) >= ROW_LIMIT - 1) begin
      closed[n] = close_run(last_pix, run_len, int'(pix_pos));
      n++;
      last_pix    = '0;
      run_len     = '0;
      pix_pos     = '0;
      runs_closed = '0;
      match_pos   = '0;
      found_seen  = 1'b0;
    end else begin
      pix_pos = pix_pos + 12'd1;
    end
    if (n > 0) closed[n-1].last_result = 1'b1;
    for (i = 0; i < n; i++) pending_runs.push_back(closed[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 2) begin
      out_stall  <= 1'b1;
      // mostly short bursts, now and then a long one to back up the queue
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        note_error($sformatf("result with nothing pending: %s", run_text(out_data)));
      end else begin
        want = pending_runs.pop_front();
        bad  = "";
        if (out_data.segment_number !== want.segment_number) bad = {bad, " segment_number"};
        if (out_data.color_class    !== want.color_class)    bad = {bad, " color_class"};
        if (out_data.run_length     !== want.run_length)     bad = {bad, " run_length"};
        if (out_data.midpoint       !== want.midpoint)       bad = {bad, " midpoint"};
        if (out_data.pattern_found  !== want.pattern_found)  bad = {bad, " pattern_found"};
        if (out_data.last_result    !== want.last_result)    bad = {bad, " last_result"};
        if (bad != "")
          note_error($sformatf("mismatch in%s: expected %s, got %s",
                               bad, run_text(want), run_text(out_data)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Sends one pixel request, with an occasional idle gap in front; returns in
  // the time step of acceptance, valid still high so back-to-back requests
  // need no extra edge.
  task automatic send_pixel(input logic [7:0] pix, input logic rend);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 4) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel: pix, row_end: rend};
    do @(posedge clk); while (in_stall);
    predict_pixel(pix, rend);
    pixels_sent++;
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // waits on for a pixel that closed nothing and may still be in flight.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input int idx, input logic [1:0] wval,
                            output logic [CFG_DATA_W-1:0] rval);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_ADDR_W'(idx * REG_STRIDE);
    cfg_pwdata  <= CFG_DATA_W'(wval);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rval = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_pattern_regs();
    logic [CFG_DATA_W-1:0] rd;
    int                    i;
    for (i = 0; i < PAT_LEN; i++) begin
      cfg_access(1'b0, i, 2'b00, rd);
      if (rd !== CFG_DATA_W'(pattern_regs[i]))
        note_error($sformatf("pattern_%0d reads 0x%0h, expected 0x%0h",
                             i, rd, pattern_regs[i]));
    end
  endtask

  // Writes all five pattern registers once the block has gone idle, then reads them back.
  task automatic set_patterns(input pattern_t next_pat);
    logic [CFG_DATA_W-1:0] rd;
    int                    i;
    wait_until_idle();
    for (i = 0; i < PAT_LEN; i++) begin
      cfg_access(1'b1, i, next_pat[i], rd);
      pattern_regs[i] = next_pat[i];
    end
    check_pattern_regs();
  endtask

  // One random row. Mostly well formed: runs whose classes follow the current
  // pattern with the odd wrong class and random lengths. One in eight is noise:
  // raw pixels with random row ends.
  task automatic send_random_row();
    int         n_runs;
    int         len;
    int         offset;
    int         j;
    int         k;
    logic [1:0] cls;
    logic [7:0] pix;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12))
        send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end else begin
      n_runs = $urandom_range(1, 9);
      offset = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAT_LEN - 1) : 0;
      for (j = 0; j < n_runs; j++) begin
        cls = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                          : pattern_regs[(j + offset) % PAT_LEN];
        case (cls)
          CLS_BLACK: pix = PIX_BLACK;
          CLS_GRAY:  pix = PIX_GRAY;
          CLS_WHITE: pix = PIX_WHITE;
          default: begin
            pix = 8'($urandom_range(1, 254));
            if (pix == PIX_GRAY) pix = 8'($urandom_range(1, 127));
          end
        endcase
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        for (k = 0; k < len; k++)
          send_pixel(pix, (j == n_runs - 1) && (k == len - 1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset pattern black-white-gray-white-black: a clean hit, then a row where
  // the matcher misses after two entries and restarts on the first one.
  task automatic test_default_pattern();
    check_pattern_regs();
    send_pixel(PIX_BLACK, 1'b0);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_GRAY,  1'b0);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_BLACK, 1'b1);
    send_pixel(PIX_BLACK, 1'b0);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_BLACK, 1'b0);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_GRAY,  1'b0);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_BLACK, 1'b1);
  endtask

  // Row boundary cases and pixel bit extremes.
  task automatic test_row_edges();
    send_pixel(8'hFF, 1'b1);         // single-pixel row
    send_pixel(8'h00, 1'b0);         // value change on the last pixel: two results
    send_pixel(8'h80, 1'b1);
    send_pixel(8'h55, 1'b0);         // same value on the last pixel: one result
    send_pixel(8'h55, 1'b1);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'hFE, 1'b0);
    send_pixel(8'h7F, 1'b1);
    send_pixel(8'h81, 1'b0);
    send_pixel(8'h81, 1'b0);
    send_pixel(8'h00, 1'b1);
  endtask

  // All-zero and all-three patterns, each with a batch of random rows.
  task automatic test_pattern_extremes();
    int start;
    set_patterns({PAT_LEN{CLS_OTHER}});
    start = pixels_sent;
    while (pixels_sent - start < 80) send_random_row();
    set_patterns({PAT_LEN{CLS_WHITE}});
    start = pixels_sent;
    while (pixels_sent - start < 80) send_random_row();
  endtask

  // Random rows under a new random pattern per phase. Phase 2 runs with no
  // idling on either side; phase 4 holds the sender until everything drained.
  task automatic test_random_traffic();
    pattern_t next_pat;
    int       phase;
    int       start;
    int       i;
    bit       paused;
    paused = 1'b0;
    for (phase = 0; phase < 6; phase++) begin
      for (i = 0; i < PAT_LEN; i++) next_pat[i] = 2'($urandom_range(0, 3));
      set_patterns(next_pat);
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);
      start = pixels_sent;
      while (pixels_sent - start < 150) begin
        if (phase == 4 && !paused && pixels_sent - start >= 75) begin
          wait_until_idle();
          paused = 1'b1;
        end
        send_random_row();
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_pattern();
    test_row_edges();
    test_pattern_extremes();
    test_random_traffic();

    // drain, then give a stray result time to show up
    wait_until_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard, far above the slowest correct run
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
